@@ rtl/kcd_pkg.sv @@
package kcd_pkg;

    // Graph size and derived widths
    localparam int MAX_V = 64;
    localparam int VW = $clog2(MAX_V);
    localparam int CW = $clog2(MAX_V + 1);
    localparam int LW = 6;
    localparam int CFG_W = 7;
    localparam int FIELD_W = 6;
    localparam int POP_GROUPS = (MAX_V + 7) / 8;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(64);

    // Input word kinds
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_RUN = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // One degree word coming out of the degree RAM during a scan
    typedef struct packed {
        logic          valid;
        logic [VW-1:0] idx;
        logic [CW-1:0] deg;
        logic          nb;
        logic          removed;
    } scan_in_t;

    // Degree write-back from the compare unit
    typedef struct packed {
        logic          en;
        logic [VW-1:0] idx;
        logic [CW-1:0] deg;
    } deg_wr_t;

    // Bit count of one adjacency row: per-byte counts, then a sum of bytes
    function automatic logic [CW-1:0] popcount(input logic [MAX_V-1:0] x);
        logic [POP_GROUPS*8-1:0] xp;
        logic [3:0]              g;
        logic [CW-1:0]           s;
        xp = '0;
        xp[MAX_V-1:0] = x;
        s = '0;
        for (int gi = 0; gi < POP_GROUPS; gi++) begin
            g = '0;
            for (int bi = 0; bi < 8; bi++) begin
                g = g + 4'(xp[gi*8+bi]);
            end
            s = s + CW'(g);
        end
        return s;
    endfunction

endpackage

@@ rtl/kcd_ram.sv @@
module kcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kcd_adj_mem.sv @@
module kcd_adj_mem (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     clear,
    input  logic                     we,
    input  logic [kcd_pkg::VW-1:0]    waddr,
    input  logic [kcd_pkg::MAX_V-1:0] wdata,
    input  logic [kcd_pkg::VW-1:0]    raddr,
    output logic [kcd_pkg::MAX_V-1:0] rdata
);

    logic [kcd_pkg::MAX_V-1:0] mem [kcd_pkg::MAX_V];
    logic [kcd_pkg::MAX_V-1:0] row_valid_reg;
    logic [kcd_pkg::MAX_V-1:0] rdata_reg;

    // Row storage; a row never written since the last clear reads as empty
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= row_valid_reg[raddr] ? mem[raddr] : '0;
    end

    // Per-row valid bits, dropped all at once by a clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (clear) begin
            row_valid_reg <= '0;
        end else if (we) begin
            row_valid_reg[waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kcd_min_unit.sv @@
module kcd_min_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  kcd_pkg::scan_in_t     scan_in,
    output kcd_pkg::deg_wr_t      deg_wr,
    output logic                  best_valid,
    output logic [kcd_pkg::VW-1:0] best_idx,
    output logic [kcd_pkg::CW-1:0] best_deg
);

    logic                   best_valid_reg;
    logic [kcd_pkg::VW-1:0] best_idx_reg;
    logic [kcd_pkg::CW-1:0] best_deg_reg;
    logic                   dec;
    logic [kcd_pkg::CW-1:0] new_deg;
    logic                   take;

    // Neighbor of the last removed vertex loses one degree on the way past
    always_comb begin
        dec = scan_in.valid && scan_in.nb && !scan_in.removed && (scan_in.deg != '0);
        new_deg = scan_in.deg - kcd_pkg::CW'(dec);
        deg_wr.en = dec;
        deg_wr.idx = scan_in.idx;
        deg_wr.deg = new_deg;
        // strict less-than keeps the lowest index on ties
        take = scan_in.valid && !scan_in.removed &&
               (!best_valid_reg || (new_deg < best_deg_reg));
    end

    // Running minimum over one scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
        end else if (clear) begin
            best_valid_reg <= 1'b0;
        end else if (take) begin
            best_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg <= scan_in.idx;
            best_deg_reg <= new_deg;
        end
    end

    assign best_valid = best_valid_reg;
    assign best_idx = best_idx_reg;
    assign best_deg = best_deg_reg;

endmodule

@@ rtl/kcore_decomposition.sv @@
// Channel | Ports                                      | Direction
// s_      | s_valid s_ready s_kind s_end_a s_end_b     | in: add edge, run, clear
// m_      | m_valid m_ready m_vertex m_core_number m_last | out: one word per vertex
// cfg_    | cfg_valid cfg_ready cfg_data               | in: vertex count
//
// Add edge: the accept plus a read-modify-write of both rows. Clear: done in the accept.
// Run with n vertices: the accept, degree init over n rows, then n peel steps
// (each one pass of the shared compare unit over the degree RAM),
// then the result words, one per vertex.
// Reset is synchronous, active low; it empties the graph and sets the count to 64.
// s_ready is high only between items; a stalled m_ready holds the result word.
module kcore_decomposition (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic [kcd_pkg::FIELD_W-1:0] s_end_a,
    input  logic [kcd_pkg::FIELD_W-1:0] s_end_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [kcd_pkg::FIELD_W-1:0] m_vertex,
    output logic [kcd_pkg::LW-1:0]      m_core_number,
    output logic                       m_last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kcd_pkg::CFG_W-1:0]   cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ADD_A = 4'd1;
    localparam logic [3:0] ST_ADD_B = 4'd2;
    localparam logic [3:0] ST_ADD_W = 4'd3;
    localparam logic [3:0] ST_INIT  = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_PICK  = 4'd6;
    localparam logic [3:0] ST_ROW   = 4'd7;
    localparam logic [3:0] ST_E_RD  = 4'd8;
    localparam logic [3:0] ST_E_LD  = 4'd9;
    localparam logic [3:0] ST_E_OUT = 4'd10;

    logic [3:0]                    state_reg, state_next;
    logic [kcd_pkg::VW-1:0]        a_reg, a_next;
    logic [kcd_pkg::VW-1:0]        b_reg, b_next;
    logic [kcd_pkg::CW-1:0]        cnt_reg, cnt_next;
    logic [kcd_pkg::CW-1:0]        step_reg, step_next;
    logic                          p_valid_reg, p_valid_next;
    logic [kcd_pkg::VW-1:0]        p_idx_reg, p_idx_next;
    logic [kcd_pkg::LW-1:0]        level_reg, level_next;
    logic [kcd_pkg::MAX_V-1:0]     removed_reg, removed_next;
    logic [kcd_pkg::MAX_V-1:0]     nb_reg, nb_next;
    logic [kcd_pkg::CFG_W-1:0]     vcount_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [kcd_pkg::FIELD_W-1:0]   m_vertex_reg, m_vertex_next;
    logic [kcd_pkg::LW-1:0]        m_core_reg, m_core_next;
    logic                          m_last_reg, m_last_next;

    logic [kcd_pkg::CW-1:0]        n_eff;
    logic [kcd_pkg::MAX_V-1:0]     active;
    logic                          rd_go;
    logic [kcd_pkg::LW-1:0]        new_level;

    logic                          adj_clear, adj_we;
    logic [kcd_pkg::VW-1:0]        adj_waddr, adj_raddr;
    logic [kcd_pkg::MAX_V-1:0]     adj_wdata, adj_rdata;

    logic                          deg_we;
    logic [kcd_pkg::VW-1:0]        deg_waddr, deg_raddr;
    logic [kcd_pkg::CW-1:0]        deg_wdata, deg_rdata;

    logic                          core_we;
    logic [kcd_pkg::VW-1:0]        core_waddr, core_raddr;
    logic [kcd_pkg::LW-1:0]        core_wdata, core_rdata;

    logic                          min_clear;
    kcd_pkg::scan_in_t             scan_in;
    kcd_pkg::deg_wr_t              scan_wr;
    logic                          best_valid;
    logic [kcd_pkg::VW-1:0]        best_idx;
    logic [kcd_pkg::CW-1:0]        best_deg;

    // Storage and the shared compare unit
    kcd_adj_mem u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (adj_clear),
        .we      (adj_we),
        .waddr   (adj_waddr),
        .wdata   (adj_wdata),
        .raddr   (adj_raddr),
        .rdata   (adj_rdata)
    );

    kcd_ram #(.WIDTH(kcd_pkg::CW), .DEPTH(kcd_pkg::MAX_V)) u_deg (
        .aclk  (aclk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    kcd_ram #(.WIDTH(kcd_pkg::LW), .DEPTH(kcd_pkg::MAX_V)) u_core (
        .aclk  (aclk),
        .we    (core_we),
        .waddr (core_waddr),
        .wdata (core_wdata),
        .raddr (core_raddr),
        .rdata (core_rdata)
    );

    kcd_min_unit u_min (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (min_clear),
        .scan_in    (scan_in),
        .deg_wr     (scan_wr),
        .best_valid (best_valid),
        .best_idx   (best_idx),
        .best_deg   (best_deg)
    );

    // Effective vertex count, clamped to 1 .. MAX_V, and its mask
    always_comb begin
        if (vcount_reg == '0) begin
            n_eff = kcd_pkg::CW'(1);
        end else if (vcount_reg > kcd_pkg::CFG_W'(kcd_pkg::MAX_V)) begin
            n_eff = kcd_pkg::CW'(kcd_pkg::MAX_V);
        end else begin
            n_eff = kcd_pkg::CW'(vcount_reg);
        end
        for (int i = 0; i < kcd_pkg::MAX_V; i++) begin
            active[i] = kcd_pkg::CW'(i) < n_eff;
        end
    end

    assign rd_go = cnt_reg < n_eff;
    assign new_level = ({1'b0, level_reg} < kcd_pkg::CW'(best_deg)) ?
                       kcd_pkg::LW'(best_deg) : level_reg;

    // Words seen by the compare unit: registered degree plus flags of that vertex
    always_comb begin
        scan_in.valid = p_valid_reg && (state_reg == ST_SCAN);
        scan_in.idx = p_idx_reg;
        scan_in.deg = deg_rdata;
        scan_in.nb = nb_reg[p_idx_reg];
        scan_in.removed = removed_reg[p_idx_reg];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        p_valid_next = 1'b0;
        p_idx_next = cnt_reg[kcd_pkg::VW-1:0];
        level_next = level_reg;
        removed_next = removed_reg;
        nb_next = nb_reg;
        m_valid_next = m_valid_reg;
        m_vertex_next = m_vertex_reg;
        m_core_next = m_core_reg;
        m_last_next = m_last_reg;

        adj_clear = 1'b0;
        adj_we = 1'b0;
        adj_waddr = a_reg;
        adj_wdata = '0;
        adj_raddr = cnt_reg[kcd_pkg::VW-1:0];
        deg_we = 1'b0;
        deg_waddr = p_idx_reg;
        deg_wdata = '0;
        deg_raddr = cnt_reg[kcd_pkg::VW-1:0];
        core_we = 1'b0;
        core_waddr = best_idx;
        core_wdata = new_level;
        core_raddr = cnt_reg[kcd_pkg::VW-1:0];
        min_clear = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next = s_end_a[kcd_pkg::VW-1:0];
                    b_next = s_end_b[kcd_pkg::VW-1:0];
                    unique case (s_kind)
                        kcd_pkg::KIND_ADD: begin
                            if ((s_end_a != s_end_b) && (32'(s_end_a) < kcd_pkg::MAX_V) &&
                                (32'(s_end_b) < kcd_pkg::MAX_V)) begin
                                state_next = ST_ADD_A;
                            end
                        end
                        kcd_pkg::KIND_RUN: begin
                            state_next = ST_INIT;
                            cnt_next = '0;
                        end
                        kcd_pkg::KIND_CLEAR: begin
                            adj_clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // Edge load: read row a, write it and read row b, write row b
            ST_ADD_A: begin
                adj_raddr = a_reg;
                state_next = ST_ADD_B;
            end
            ST_ADD_B: begin
                adj_we = 1'b1;
                adj_waddr = a_reg;
                adj_wdata = adj_rdata | (kcd_pkg::MAX_V'(1) << b_reg);
                adj_raddr = b_reg;
                state_next = ST_ADD_W;
            end
            ST_ADD_W: begin
                adj_we = 1'b1;
                adj_waddr = b_reg;
                adj_wdata = adj_rdata | (kcd_pkg::MAX_V'(1) << a_reg);
                state_next = ST_IDLE;
            end
            // Initial degrees: one row read per cycle, its count written in the cycle after the read
            ST_INIT: begin
                if (rd_go) begin
                    cnt_next = cnt_reg + kcd_pkg::CW'(1);
                end
                p_valid_next = rd_go;
                if (p_valid_reg) begin
                    deg_we = 1'b1;
                    deg_wdata = kcd_pkg::popcount(adj_rdata & active);
                end
                if (!rd_go && !p_valid_reg) begin
                    state_next = ST_SCAN;
                    cnt_next = '0;
                    step_next = '0;
                    level_next = '0;
                    removed_next = '0;
                    nb_next = '0;
                    min_clear = 1'b1;
                end
            end
            // Scan: apply pending decrements and track the minimum
            ST_SCAN: begin
                if (rd_go) begin
                    cnt_next = cnt_reg + kcd_pkg::CW'(1);
                end
                p_valid_next = rd_go;
                deg_we = scan_wr.en;
                deg_waddr = scan_wr.idx;
                deg_wdata = scan_wr.deg;
                if (!rd_go && !p_valid_reg) begin
                    state_next = ST_PICK;
                end
            end
            // Remove the winner, record its core number, fetch its row
            ST_PICK: begin
                core_we = 1'b1;
                level_next = new_level;
                removed_next[best_idx] = 1'b1;
                adj_raddr = best_idx;
                step_next = step_reg + kcd_pkg::CW'(1);
                state_next = ST_ROW;
            end
            ST_ROW: begin
                nb_next = adj_rdata;
                cnt_next = '0;
                if (step_reg == n_eff) begin
                    state_next = ST_E_RD;
                end else begin
                    state_next = ST_SCAN;
                    min_clear = 1'b1;
                end
            end
            // Result words in index order
            ST_E_RD: begin
                state_next = ST_E_LD;
            end
            ST_E_LD: begin
                m_valid_next = 1'b1;
                m_vertex_next = kcd_pkg::FIELD_W'(cnt_reg[kcd_pkg::VW-1:0]);
                m_core_next = core_rdata;
                m_last_next = (cnt_reg == (n_eff - kcd_pkg::CW'(1)));
                state_next = ST_E_OUT;
            end
            ST_E_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + kcd_pkg::CW'(1);
                        state_next = ST_E_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            vcount_reg <= kcd_pkg::VCOUNT_RESET;
            cnt_reg <= '0;
            step_reg <= '0;
            level_reg <= '0;
            removed_reg <= '0;
        end else begin
            state_reg <= state_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            cnt_reg <= cnt_next;
            step_reg <= step_next;
            level_reg <= level_next;
            removed_reg <= removed_next;
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_idx_reg <= p_idx_next;
        nb_reg <= nb_next;
        m_vertex_reg <= m_vertex_next;
        m_core_reg <= m_core_next;
        m_last_reg <= m_last_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_vertex = m_vertex_reg;
    assign m_core_number = m_core_reg;
    assign m_last = m_last_reg;

    // A peel step always has a remaining vertex to remove
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |-> best_valid)
        else $error("peel step without a candidate");

    // Peel level never drops within a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PICK) |=> (level_reg >= $past(level_reg)))
        else $error("peel level decreased");

    // Decrements only touch vertices still in the graph
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && deg_we) |-> !removed_reg[deg_waddr])
        else $error("degree write to a removed vertex");

    // A result word is shown only while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_E_OUT))
        else $error("result valid outside output state");

endmodule

@@ tb/kcd_checker.sv @@
`timescale 1ns / 100ps

module kcd_checker
    import kcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [FIELD_W-1:0] s_end_a,
    input  logic [FIELD_W-1:0] s_end_b,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [FIELD_W-1:0] m_vertex,
    input  logic [LW-1:0]      m_core_number,
    input  logic               m_last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    output int                 fail_count,
    output int                 words_pending
);

    typedef struct packed {
        logic [FIELD_W-1:0] vertex;
        logic [LW-1:0]      core_number;
        logic               last;
    } core_word_t;

    // Shadow of the graph and the vertex count register
    logic [MAX_V-1:0] adj_rows [MAX_V];
    logic [CFG_W-1:0] vertex_cnt;
    core_word_t       expected_cores [$];
    int               errs = 0;

    initial begin
        fail_count = 0;
        words_pending = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        errs++;
    endtask

    // Peel the graph: lowest remaining degree goes first, lowest index on ties
    task automatic predict_cores();
        int               n;
        int               pick;
        int               pick_deg;
        int               level;
        int               deg_left [MAX_V];
        logic [LW-1:0]    core_of [MAX_V];
        logic [MAX_V-1:0] in_use;
        logic [MAX_V-1:0] gone;
        logic [MAX_V-1:0] nbrs;
        core_word_t       w;
        n = (vertex_cnt == 0) ? 1 : ((vertex_cnt > MAX_V) ? MAX_V : int'(vertex_cnt));
        in_use = (n >= MAX_V) ? '1 : ((MAX_V'(1) << n) - 1);
        for (int v = 0; v < n; v++) begin
            deg_left[v] = $countones(adj_rows[v] & in_use);
        end
        gone = '0;
        level = 0;
        for (int step = 0; step < n; step++) begin
            pick = -1;
            pick_deg = 0;
            for (int v = 0; v < n; v++) begin
                if (!gone[v] && (pick < 0 || deg_left[v] < pick_deg)) begin
                    pick = v;
                    pick_deg = deg_left[v];
                end
            end
            if (pick_deg > level) level = pick_deg;
            core_of[pick] = LW'(level);
            gone[pick] = 1'b1;
            nbrs = adj_rows[pick] & in_use & ~gone;
            for (int v = 0; v < n; v++) begin
                if (nbrs[v] && deg_left[v] > 0) deg_left[v]--;
            end
        end
        // one word per vertex, index order
        for (int v = 0; v < n; v++) begin
            w.vertex = FIELD_W'(v);
            w.core_number = core_of[v];
            w.last = (v == n - 1);
            expected_cores = {expected_cores, w};
        end
    endtask

    task automatic apply_word(input logic [1:0] kind, input logic [FIELD_W-1:0] a,
                              input logic [FIELD_W-1:0] b);
        case (kind)
            KIND_ADD: begin
                // self-loops dropped; repeats are harmless
                if (a != b) begin
                    adj_rows[a][b] = 1'b1;
                    adj_rows[b][a] = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int r = 0; r < MAX_V; r++) adj_rows[r] = '0;
            end
            KIND_RUN: begin
                predict_cores();
            end
            default: ;
        endcase
    endtask

    task automatic check_word();
        core_word_t want;
        if (expected_cores.size() == 0) begin
            report_mismatch("unexpected word, vertex", int'(m_vertex), -1);
            return;
        end
        want = expected_cores.pop_front();
        if (m_vertex !== want.vertex)
            report_mismatch("vertex", int'(m_vertex), int'(want.vertex));
        if (m_core_number !== want.core_number)
            report_mismatch("core_number", int'(m_core_number), int'(want.core_number));
        if (m_last !== want.last)
            report_mismatch("last", int'(m_last), int'(want.last));
    endtask

    // Watch all three channels; results first so a new run queues behind them
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MAX_V; r++) adj_rows[r] = '0;
            vertex_cnt = VCOUNT_RESET;
            expected_cores.delete();
        end else begin
            if (m_valid && m_ready) check_word();
            if (cfg_valid && cfg_ready) vertex_cnt = cfg_data;
            if (s_valid && s_ready) apply_word(s_kind, s_end_a, s_end_b);
        end
        words_pending <= expected_cores.size();
        fail_count <= errs;
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import kcd_pkg::*;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int PHASES = 14;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 400;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_ADD;
    logic [FIELD_W-1:0] s_end_a = '0;
    logic [FIELD_W-1:0] s_end_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [FIELD_W-1:0] m_vertex;
    logic [LW-1:0]      m_core_number;
    logic               m_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;
    int                 fail_count;
    int                 words_pending;
    int                 cycle_no = 0;

    // vertex count per random phase, extremes included
    int phase_counts [PHASES] = '{64, 3, 1, 12, 2, 20, 8, 64, 5, 16, 127, 10, 0, 24};

    // stretch of cycles where neither side idles
    wire calm = (cycle_no >= 15000) && (cycle_no < 30000);

    kcore_decomposition dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_end_a       (s_end_a),
        .s_end_b       (s_end_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex      (m_vertex),
        .m_core_number (m_core_number),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    kcd_checker core_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_end_a       (s_end_a),
        .s_end_b       (s_end_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex      (m_vertex),
        .m_core_number (m_core_number),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_no <= cycle_no + 1;

    initial begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, one long hold-off once results are flowing
    initial begin
        int  words_taken;
        bit  held;
        words_taken = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) words_taken++;
            if (!held && words_taken >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic [1:0] kind, input logic [FIELD_W-1:0] a,
                             input logic [FIELD_W-1:0] b);
        while (!calm && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_end_a <= a;
        s_end_b <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Let every expected word out, then give an add time to finish
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_count(input int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                 n_eff;
        int                 span;
        int                 sent;
        int                 adds;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty graph at the reset count of 64
        send_word(KIND_RUN, 6'd0, 6'd0);
        write_count(6);
        send_word(KIND_ADD, 6'd0, 6'd1);
        send_word(KIND_ADD, 6'd1, 6'd2);
        send_word(KIND_ADD, 6'd2, 6'd0);
        send_word(KIND_ADD, 6'd4, 6'd4);    // self-loop
        send_word(KIND_ADD, 6'd1, 6'd0);    // repeat of an edge
        send_word(KIND_ADD, 6'd3, 6'd4);
        send_word(KIND_ADD, 6'd5, 6'd63);   // stored, beyond the count
        send_word(KIND_ADD, 6'd63, 6'd0);
        send_word(KIND_RESERVED, 6'd63, 6'd63);
        send_word(KIND_RUN, 6'd63, 6'd63);
        send_word(KIND_CLEAR, 6'd0, 6'd63);
        send_word(KIND_RUN, 6'd0, 6'd0);
        send_word(KIND_ADD, 6'd3, 6'd5);
        send_word(KIND_ADD, 6'd4, 6'd5);
        send_word(KIND_ADD, 6'd3, 6'd4);
        send_word(KIND_ADD, 6'd0, 6'd3);
        send_word(KIND_RUN, 6'd0, 6'd0);
        // zero count acts as one vertex, oversize as the full matrix
        write_count(0);
        send_word(KIND_RUN, 6'd0, 6'd0);
        write_count(127);
        send_word(KIND_RUN, 6'd0, 6'd0);

        // Random: per phase, graphs built from edges and then peeled
        for (int p = 0; p < PHASES; p++) begin
            write_count(phase_counts[p]);
            n_eff = (phase_counts[p] == 0) ? 1 :
                    ((phase_counts[p] > MAX_V) ? MAX_V : phase_counts[p]);
            sent = 0;
            while (sent < 24) begin
                if ($urandom_range(3) == 0) begin
                    send_word(KIND_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
                    sent++;
                end
                // a tight cluster now and then gives higher cores
                span = ($urandom_range(1) == 0 && n_eff > 9) ? 9 : n_eff;
                adds = $urandom_range(1, (n_eff > 8) ? 30 : 2 * n_eff + 1);
                repeat (adds) begin
                    if ($urandom_range(19) == 0)
                        send_word(KIND_RESERVED, FIELD_W'($urandom), FIELD_W'($urandom));
                    if ($urandom_range(4) != 0) begin
                        a = FIELD_W'($urandom_range(span - 1));
                        b = FIELD_W'($urandom_range(span - 1));
                    end else begin
                        a = FIELD_W'($urandom);
                        b = FIELD_W'($urandom);
                    end
                    send_word(KIND_ADD, a, b);
                    sent++;
                end
                send_word(KIND_RUN, FIELD_W'($urandom), FIELD_W'($urandom));
                sent++;
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
